// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/psr_pkg.sv -----
`default_nettype none

package psr_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_ITER_DEF  = 16;

  // fixed port field widths
  localparam int IN_W    = 16;
  localparam int PHASE_W = 16;
  localparam int RATIO_W = 24;

  // angle accumulator width, Q2.30 plus headroom
  localparam int ZW = 34;

  // DFT weights in Q16 for angles 72 and 144 degrees
  localparam int W_COS72  = 20252;
  localparam int W_COS144 = -53020;
  localparam int W_SIN72  = 62328;
  localparam int W_SIN144 = 38521;

  localparam int HALF_PI_Q30 = 1686629713;
  localparam int PHASE_LIMIT = 25736;

  // arctan(2^-i) in Q2.30, rounded
  localparam int TAB_LEN = 24;
  localparam logic [29:0] ATAN_Q30 [TAB_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128
  };

  typedef struct packed {
    logic [IN_W-1:0] fg_step_0;
    logic [IN_W-1:0] fg_step_1;
    logic [IN_W-1:0] fg_step_2;
    logic [IN_W-1:0] fg_step_3;
    logic [IN_W-1:0] fg_step_4;
    logic [IN_W-1:0] bg_step_0;
    logic [IN_W-1:0] bg_step_1;
    logic [IN_W-1:0] bg_step_2;
    logic [IN_W-1:0] bg_step_3;
    logic [IN_W-1:0] bg_step_4;
  } in_t;

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase_difference;
    logic [RATIO_W-1:0]        absorption_ratio;
    logic [RATIO_W-1:0]        visibility_ratio;
    logic                      divide_fault;
  } out_t;

  // number of CORDIC micro-rotations actually built
  function automatic int cordic_n(input int n);
    return (n > TAB_LEN) ? TAB_LEN : n;
  endfunction

  // magnitude width: the Q8-rounded components are sample_bits + 11 bits signed
  function automatic int mag_w(input int sb);
    return sb + 11;
  endfunction

  // lane latency: three DFT stages, then the longer of angle and magnitude paths
  function automatic int lane_lat(input int sb, input int n);
    int a;
    int m;
    a = 1 + cordic_n(n);
    m = 3 + mag_w(sb);
    return 3 + ((a > m) ? a : m);
  endfunction

endpackage

`default_nettype wire

// ----- design/psr_dly.sv -----
`default_nettype none

// Fixed-depth delay line that advances with the pipeline enable.
module psr_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] tap_r [DEPTH];

      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= d;
          for (int i = 1; i < DEPTH; i++) begin
            tap_r[i] <= tap_r[i-1];
          end
        end
      end

      assign q = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

`default_nettype wire

// ----- design/psr_div.sv -----
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Quotient saturates to all ones when it would not fit in Q_W bits.
module psr_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 19,
  parameter int Q_W   = 24
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_r [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             sat_r [Q_W+1];

  // entry stage: overflow check against den * 2^Q_W
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= (CW'(num) >= (CW'(den) << Q_W));
    end
  end

  generate
    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      localparam int BIT = Q_W - k;
      logic [CW-1:0] dsh;
      logic          take;

      assign dsh  = CW'(den_r[k-1]) << BIT;
      assign take = (rem_r[k-1] >= dsh);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]      <= take ? rem_r[k-1] - dsh : rem_r[k-1];
          den_r[k]      <= den_r[k-1];
          sat_r[k]      <= sat_r[k-1];
          q_r[k]        <= q_r[k-1] | (Q_W'(take) << BIT);
        end
      end
    end
  endgenerate

  assign quo = sat_r[Q_W] ? '1 : q_r[Q_W];

endmodule

`default_nettype wire

// ----- design/psr_lane.sv -----
`default_nettype none

// One sample set: five-point first harmonic, CORDIC phase, integer
// magnitude and sample sum, all pipelined and aligned at the outputs.
module psr_lane #(
  parameter int SAMPLE_BITS      = psr_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_ITERATIONS = psr_pkg::ANGLE_ITER_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [4:0][psr_pkg::IN_W-1:0]      smp,
  output logic signed [psr_pkg::ZW-1:0]           phase,
  output logic [psr_pkg::mag_w(SAMPLE_BITS)-1:0]  mag,
  output logic [SAMPLE_BITS+2:0]                  sum
);

  localparam int SB     = SAMPLE_BITS;
  localparam int RE_W   = SB + 18;
  localparam int XW     = RE_W + 3;
  localparam int ZW     = psr_pkg::ZW;
  localparam int N      = psr_pkg::cordic_n(ANGLE_ITERATIONS);
  localparam int MAG_W  = psr_pkg::mag_w(SB);
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RW     = MAG_W + 2;
  localparam int SUM_W  = SB + 3;
  localparam int LAT    = psr_pkg::lane_lat(SB, ANGLE_ITERATIONS);
  localparam int PH_DLY = LAT - 4 - N;
  localparam int MG_DLY = LAT - 6 - MAG_W;
  localparam int SM_DLY = LAT - 1;

  // ---- stage 1: pair sums and differences, sample sum
  logic [SB-1:0]        x [5];
  logic [SB-1:0]        x0_r;
  logic [SB:0]          a14_r, a23_r;
  logic signed [SB:0]   d14_r, d23_r;
  logic [SUM_W-1:0]     sum_r;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      x[k] = smp[k][SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x[0];
      a14_r <= (SB+1)'(x[1]) + (SB+1)'(x[4]);
      a23_r <= (SB+1)'(x[2]) + (SB+1)'(x[3]);
      d14_r <= signed'((SB+1)'(x[1]) - (SB+1)'(x[4]));
      d23_r <= signed'((SB+1)'(x[2]) - (SB+1)'(x[3]));
      sum_r <= SUM_W'(x[0]) + SUM_W'(x[1]) + SUM_W'(x[2]) + SUM_W'(x[3]) + SUM_W'(x[4]);
    end
  end

  // ---- stage 2: constant-weight products
  logic signed [RE_W-1:0] p0_r, pc72_r, pc144_r, ps72_r, ps144_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= signed'(RE_W'({x0_r, 16'h0000}));
      pc72_r  <= signed'(RE_W'(a14_r)) * RE_W'(psr_pkg::W_COS72);
      pc144_r <= signed'(RE_W'(a23_r)) * RE_W'(psr_pkg::W_COS144);
      ps72_r  <= RE_W'(d14_r) * RE_W'(psr_pkg::W_SIN72);
      ps144_r <= RE_W'(d23_r) * RE_W'(psr_pkg::W_SIN144);
    end
  end

  // ---- stage 3: harmonic real and imaginary parts (Q16)
  logic signed [RE_W-1:0] re_r, im_r;

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= p0_r + pc72_r + pc144_r;
      im_r <= ps72_r + ps144_r;
    end
  end

  // ---- CORDIC vectoring: quarter-turn pre-rotation, then N micro-rotations
  logic signed [XW-1:0] cx_r [N+1];
  logic signed [XW-1:0] cy_r [N+1];
  logic signed [ZW-1:0] cz_r [N+1];
  logic                 cnul_r [N+1];
  logic signed [XW-1:0] re_x, im_x;

  assign re_x = XW'(re_r);
  assign im_x = XW'(im_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cnul_r[0] <= (re_r == '0) && (im_r == '0);
      if (re_r[RE_W-1] && !im_r[RE_W-1]) begin
        cx_r[0] <= im_x;
        cy_r[0] <= -re_x;
        cz_r[0] <= ZW'(psr_pkg::HALF_PI_Q30);
      end else if (re_r[RE_W-1]) begin
        cx_r[0] <= -im_x;
        cy_r[0] <= re_x;
        cz_r[0] <= -ZW'(psr_pkg::HALF_PI_Q30);
      end else begin
        cx_r[0] <= re_x;
        cy_r[0] <= im_x;
        cz_r[0] <= '0;
      end
    end
  end

  generate
    for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [XW-1:0] dx, dy;
      logic signed [ZW-1:0] ang;

      assign dx  = cy_r[i] >>> i;
      assign dy  = cx_r[i] >>> i;
      assign ang = signed'(ZW'(psr_pkg::ATAN_Q30[i]));

      // rotate clockwise while y is non-negative
      always_ff @(posedge clk) begin
        if (en) begin
          cnul_r[i+1] <= cnul_r[i];
          if (!cy_r[i][XW-1]) begin
            cx_r[i+1] <= cx_r[i] + dx;
            cy_r[i+1] <= cy_r[i] - dy;
            cz_r[i+1] <= cz_r[i] + ang;
          end else begin
            cx_r[i+1] <= cx_r[i] - dx;
            cy_r[i+1] <= cy_r[i] + dy;
            cz_r[i+1] <= cz_r[i] - ang;
          end
        end
      end
    end
  endgenerate

  logic signed [ZW-1:0] phase_raw;
  assign phase_raw = cnul_r[N] ? '0 : cz_r[N];

  // ---- magnitude: round to Q8, square, add
  logic signed [RE_W:0]     re_rnd, im_rnd;
  logic signed [MAG_W-1:0]  re8_r, im8_r;
  logic [SQ_W-1:0]          sqa_r, sqb_r;

  assign re_rnd = (RE_W+1)'(re_r) + (RE_W+1)'(128);
  assign im_rnd = (RE_W+1)'(im_r) + (RE_W+1)'(128);

  always_ff @(posedge clk) begin
    if (en) begin
      re8_r <= re_rnd[RE_W:8];
      im8_r <= im_rnd[RE_W:8];
      sqa_r <= SQ_W'(re8_r) * SQ_W'(re8_r);
      sqb_r <= SQ_W'(im8_r) * SQ_W'(im8_r);
    end
  end

  // ---- integer square root, one root bit per stage
  logic [SQ_W-1:0]  sval_r  [MAG_W+1];
  logic [RW-1:0]    srem_r  [MAG_W+1];
  logic [MAG_W-1:0] sroot_r [MAG_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sval_r[0]  <= sqa_r + sqb_r;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
    end
  end

  generate
    for (genvar k = 1; k <= MAG_W; k++) begin : g_sqrt
      localparam int POS = 2 * (MAG_W - k);
      logic [RW-1:0] rem_sh, trial;

      assign rem_sh = {srem_r[k-1][RW-3:0], sval_r[k-1][POS+1:POS]};
      assign trial  = {sroot_r[k-1], 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          sval_r[k] <= sval_r[k-1];
          if (rem_sh >= trial) begin
            srem_r[k]  <= rem_sh - trial;
            sroot_r[k] <= {sroot_r[k-1][MAG_W-2:0], 1'b1};
          end else begin
            srem_r[k]  <= rem_sh;
            sroot_r[k] <= {sroot_r[k-1][MAG_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // ---- align the three results
  psr_dly #(.W(ZW), .DEPTH(PH_DLY)) u_ph_dly (
    .clk (clk), .en (en), .d (phase_raw), .q (phase)
  );

  psr_dly #(.W(MAG_W), .DEPTH(MG_DLY)) u_mg_dly (
    .clk (clk), .en (en), .d (sroot_r[MAG_W]), .q (mag)
  );

  psr_dly #(.W(SUM_W), .DEPTH(SM_DLY)) u_sm_dly (
    .clk (clk), .en (en), .d (sum_r), .q (sum)
  );

endmodule

`default_nettype wire

// ----- design/phase_step_retrieval_dph_abs_vis.sv -----
// Path from input transaction to result: lanes, merge stages, dividers and the
//   output register; at the defaults the square-root stages set the lane depth.
// Throughput: one pixel per cycle while the skid slot is free; the output
//   register and a skid slot keep intake going while one result waits.
// Reset: synchronous, active low; clears valid bits and the output handshake.
`default_nettype none

module phase_step_retrieval_dph_abs_vis #(
  parameter int SAMPLE_BITS      = psr_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_ITERATIONS = psr_pkg::ANGLE_ITER_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire psr_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output psr_pkg::out_t      out_data
);

  localparam int ZW      = psr_pkg::ZW;
  localparam int MAG_W   = psr_pkg::mag_w(SAMPLE_BITS);
  localparam int SUM_W   = SAMPLE_BITS + 3;
  localparam int P_W     = MAG_W + SUM_W;
  localparam int AN_W    = SUM_W + 17;
  localparam int VN_W    = P_W + 17;
  localparam int RW      = psr_pkg::RATIO_W;
  localparam int PW      = psr_pkg::PHASE_W;
  localparam int DIV_LAT = RW + 1;
  localparam int LAT     = psr_pkg::lane_lat(SAMPLE_BITS, ANGLE_ITERATIONS);
  localparam int TOTAL   = LAT + 2 + DIV_LAT;
  localparam int SIDE_W  = PW + 2;
  localparam logic signed [ZW-18:0] PH_LIM = (ZW-17)'(psr_pkg::PHASE_LIMIT);

  logic en;
  logic skid_vld_r;
  logic out_valid_r;
  psr_pkg::out_t out_data_r, skid_r, tail;
  logic [TOTAL-1:0] vld_r;

  // pipeline moves whenever the skid slot is free
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // valid tracking through the whole pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid};
    end
  end

  // ---- two lanes: foreground and background
  logic [4:0][psr_pkg::IN_W-1:0] fg_smp, bg_smp;
  logic signed [ZW-1:0] ph_fg, ph_bg;
  logic [MAG_W-1:0]     mag_fg, mag_bg;
  logic [SUM_W-1:0]     sum_fg, sum_bg;

  assign fg_smp = {in_data.fg_step_4, in_data.fg_step_3, in_data.fg_step_2,
                   in_data.fg_step_1, in_data.fg_step_0};
  assign bg_smp = {in_data.bg_step_4, in_data.bg_step_3, in_data.bg_step_2,
                   in_data.bg_step_1, in_data.bg_step_0};

  psr_lane #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_fg (
    .clk (clk), .en (en), .smp (fg_smp), .phase (ph_fg), .mag (mag_fg), .sum (sum_fg)
  );

  psr_lane #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_bg (
    .clk (clk), .en (en), .smp (bg_smp), .phase (ph_bg), .mag (mag_bg), .sum (sum_bg)
  );

  // ---- merge stage 1: phase difference, cross products, zero checks
  logic signed [ZW:0]    ph_diff;
  logic signed [ZW-18:0] ph_sh, ph_clamp;

  assign ph_diff = (ZW+1)'(ph_fg) - (ZW+1)'(ph_bg) + (ZW+1)'(1 << 17);
  assign ph_sh   = ph_diff[ZW:18];

  always_comb begin
    if (ph_sh > PH_LIM) begin
      ph_clamp = PH_LIM;
    end else if (ph_sh < -PH_LIM) begin
      ph_clamp = -PH_LIM;
    end else begin
      ph_clamp = ph_sh;
    end
  end

  logic [P_W-1:0]   vp1_r, vp2_r;
  logic [SUM_W-1:0] as_fg_r, as_bg_r;
  logic [SIDE_W-1:0] side_r, side_tail;

  always_ff @(posedge clk) begin
    if (en) begin
      vp1_r   <= P_W'(mag_fg) * P_W'(sum_bg);
      vp2_r   <= P_W'(mag_bg) * P_W'(sum_fg);
      as_fg_r <= sum_fg;
      as_bg_r <= sum_bg;
      side_r  <= {ph_clamp[PW-1:0], (sum_bg == '0), (sum_fg == '0) || (mag_bg == '0)};
    end
  end

  // ---- merge stage 2: rounded numerators
  logic [AN_W-1:0]  an_r;
  logic [SUM_W-1:0] ad_r;
  logic [VN_W-1:0]  vn_r;
  logic [P_W-1:0]   vd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      an_r <= AN_W'({as_fg_r, 16'h0000}) + AN_W'(as_bg_r >> 1);
      ad_r <= as_bg_r;
      vn_r <= VN_W'({vp1_r, 16'h0000}) + VN_W'(vp2_r >> 1);
      vd_r <= vp2_r;
    end
  end

  // ---- dividers
  logic [RW-1:0] q_abs, q_vis;

  psr_div #(.NUM_W(AN_W), .DEN_W(SUM_W), .Q_W(RW)) u_div_abs (
    .clk (clk), .en (en), .num (an_r), .den (ad_r), .quo (q_abs)
  );

  psr_div #(.NUM_W(VN_W), .DEN_W(P_W), .Q_W(RW)) u_div_vis (
    .clk (clk), .en (en), .num (vn_r), .den (vd_r), .quo (q_vis)
  );

  psr_dly #(.W(SIDE_W), .DEPTH(1 + DIV_LAT)) u_side_dly (
    .clk (clk), .en (en), .d (side_r), .q (side_tail)
  );

  // ---- result assembly
  always_comb begin
    tail.phase_difference = signed'(side_tail[SIDE_W-1:2]);
    tail.absorption_ratio = side_tail[1] ? '0 : q_abs;
    tail.visibility_ratio = side_tail[0] ? '0 : q_vis;
    tail.divide_fault     = side_tail[1] | side_tail[0];
  end

  // ---- output register with skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_vld_r) begin
        out_data_r  <= skid_r;
        out_valid_r <= 1'b1;
        skid_vld_r  <= 1'b0;
      end else begin
        out_data_r  <= tail;
        out_valid_r <= vld_r[TOTAL-1];
      end
    end else if (vld_r[TOTAL-1] && en) begin
      skid_r     <= tail;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/psr_chk.sv -----
`default_nettype none
`include "assert_macros.svh"

// Port-level checks for the phase-stepping block.
module psr_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire psr_pkg::out_t out_data
);

  `PSR_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid, "out_valid not cleared by reset")
  `PSR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `PSR_ASSERT(a_phase_rng, out_valid |-> (out_data.phase_difference <= 16'sd25736) && (out_data.phase_difference >= -16'sd25736), "phase out of range")
  `PSR_ASSERT(a_fault_zero, out_valid && out_data.divide_fault |-> (out_data.absorption_ratio == '0) || (out_data.visibility_ratio == '0), "fault without zeroed ratio")
  `PSR_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "intake stalled without output backpressure")

endmodule

bind phase_step_retrieval_dph_abs_vis psr_chk u_psr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
